>>> rtl/core/odo_pkg.sv
// ----------------------------------------------------------------------------
// odo_pkg
// Shared constants and the arctangent table for the odometry integrator.
// ----------------------------------------------------------------------------
package odo_pkg;

    // rotation datapath and divider widths
    localparam int CORDIC_W = 34;
    localparam int DIV_W    = 58;

    localparam logic [26:0] DEG2RAD_Q32      = 27'd74961321;
    localparam logic [32:0] INV_GAIN_Q32     = 33'h0_9B74_EDA8;
    localparam logic [25:0] INV_2PI_MEGA_Q48 = 26'd44798134;
    localparam logic [20:0] MEGA             = 21'd1000000;

    // 1/10^6 scaled by 2^52 (floor) and by 2^45 (ceiling)
    localparam logic [32:0] RECIP_MEGA_Q52   = 33'd4503599627;
    localparam logic [25:0] RECIP_MEGA_Q45   = 26'd35184373;

    // atan(2^-k) as a 32-bit binary angle
    function automatic logic [31:0] atan_at(input logic [4:0] k);
        logic [31:0] v;
        case (k)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/odo_if.sv
// ----------------------------------------------------------------------------
// odo_if
// Request channels of the odometry integrator: motion sample in, pose out.
// ----------------------------------------------------------------------------
interface odo_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw_rate_deg;
    logic        [19:0] elapsed_us;

    modport source (output valid, vel_x, vel_y, yaw_rate_deg, elapsed_us, input ready);
    modport sink   (input valid, vel_x, vel_y, yaw_rate_deg, elapsed_us, output ready);
endinterface

interface odo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [15:0] heading;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] yaw_rate_rad;

    modport source (output valid, pos_x, pos_y, heading, quat_z, quat_w, yaw_rate_rad,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, heading, quat_z, quat_w, yaw_rate_rad,
                    output ready);
endinterface

>>> rtl/core/odo_cordic.sv
// ----------------------------------------------------------------------------
// odo_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, gain kept.
// ----------------------------------------------------------------------------
module odo_cordic
    import odo_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [CORDIC_W-1:0] i_x,
    input  logic signed [CORDIC_W-1:0] i_y,
    input  logic        [31:0]         i_angle,
    output logic                       o_done,
    output logic signed [CORDIC_W-1:0] o_x,
    output logic signed [CORDIC_W-1:0] o_y
);
    localparam int IW = $clog2(CORDIC_ITERATIONS + 1);

    logic                       r_busy, r_done;
    logic        [IW-1:0]       r_i;
    logic signed [CORDIC_W-1:0] r_x, r_y, r_z;
    logic                       w_fold;
    logic signed [CORDIC_W-1:0] w_dx, w_dy, w_atan;
    logic        [31:0]         w_a;

    // angles in the left half plane: negate vector and subtract pi
    assign w_fold = i_angle[31] ^ i_angle[30];
    assign w_a    = w_fold ? {~i_angle[31], i_angle[30:0]} : i_angle;
    assign w_dx   = r_y >>> r_i;
    assign w_dy   = r_x >>> r_i;
    assign w_atan = CORDIC_W'(atan_at(5'(r_i)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_i    <= '0;
        end else if (r_busy) begin
            r_i <= r_i + 1'b1;
            if (r_i == IW'(CORDIC_ITERATIONS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= w_fold ? -i_x : i_x;
            r_y <= w_fold ? -i_y : i_y;
            r_z <= CORDIC_W'($signed(w_a));
        end else if (r_busy) begin
            if (!r_z[CORDIC_W-1]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_atan;
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
endmodule

>>> rtl/core/odo_div.sv
// ----------------------------------------------------------------------------
// odo_div
// Division by one million through reciprocal multiplication: estimate,
// back-multiply, then correct from the remainder.
// ----------------------------------------------------------------------------
module odo_div
    import odo_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient
);
    localparam logic [2:0] P_IDLE = 3'd0, P_EST = 3'd1, P_BACK = 3'd2,
                           P_FIX  = 3'd3, P_SUM = 3'd4;

    logic [2:0]       r_phase;
    logic             r_done;
    logic [DIV_W-1:0] r_n, r_q;
    logic [36:0]      r_q0;
    logic [69:0]      r_prod;
    logic [36:0]      w_ma;
    logic [32:0]      w_mb;
    logic [DIV_W-1:0] w_rem;

    // estimate is low by at most 19, so the remainder stays below 2^25
    assign w_rem = r_n - r_prod[DIV_W-1:0];

    always_comb begin
        case (r_phase)
            P_EST: begin
                w_ma = r_n[55:19];
                w_mb = RECIP_MEGA_Q52;
            end
            P_BACK: begin
                w_ma = r_prod[69:33];
                w_mb = 33'(MEGA);
            end
            P_FIX: begin
                w_ma = 37'(w_rem[24:0]);
                w_mb = 33'(RECIP_MEGA_Q45);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else if (i_start) begin
            r_phase <= P_EST;
            r_done  <= 1'b0;
        end else begin
            case (r_phase)
                P_EST:  r_phase <= P_BACK;
                P_BACK: r_phase <= P_FIX;
                P_FIX:  r_phase <= P_SUM;
                P_SUM: begin
                    r_phase <= P_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_phase <= P_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        if (i_start) begin
            r_n <= i_dividend;
        end
        if (r_phase == P_BACK) begin
            r_q0 <= r_prod[69:33];
        end
        if (r_phase == P_SUM) begin
            r_q <= DIV_W'(r_q0) + DIV_W'(r_prod[69:45]);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

>>> rtl/core/planar_odometry_integrator.sv
// ----------------------------------------------------------------------------
// planar_odometry_integrator
// Dead-reckoning pose integrator: rotates body velocity by heading, scales
// by elapsed time into saturating x/y accumulators, advances the heading
// and reports the yaw quaternion.
//
//   channel   dir   payload                                        handshake
//   i_in      in    vel_x vel_y yaw_rate_deg elapsed_us            valid/ready
//   o_out     out   pos_x pos_y heading quat_z quat_w yaw_rate_rad valid/ready
//
// The two CORDIC passes dominate the time from one accept to the next.
// i_in.ready is high only while the sequencer is idle. A finished pose sits
// in the output register; the next request is accepted meanwhile and only
// its final write waits for that register to drain.
// Synchronous active-low reset clears the accumulators and the heading.
// ----------------------------------------------------------------------------
module planar_odometry_integrator
    import odo_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int HEADING_BITS      = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    odo_in_if.sink    i_in,
    odo_out_if.source o_out
);
    localparam int HSHIFT = 60 - HEADING_BITS;
    localparam int MAW    = 38;
    localparam int MBW    = 34;
    localparam int PW     = MAW + MBW;

    localparam logic [4:0] S_IDLE = 5'd0,  S_MRAD = 5'd1,  S_RAD  = 5'd2,
                           S_MHD1 = 5'd3,  S_MHD2 = 5'd4,  S_HEAD = 5'd5,
                           S_WROT = 5'd6,  S_MGX  = 5'd7,  S_MGY  = 5'd8,
                           S_GY   = 5'd9,  S_MPX  = 5'd10, S_DPX  = 5'd11,
                           S_WPX  = 5'd12, S_MPY  = 5'd13, S_DPY  = 5'd14,
                           S_WPY  = 5'd15, S_QROT = 5'd16, S_WQ   = 5'd17,
                           S_MQW  = 5'd18, S_MQZ  = 5'd19, S_QZ   = 5'd20,
                           S_OUT  = 5'd21;

    logic [4:0]                 r_state;
    logic signed [15:0]         r_vx, r_vy, r_yd, r_rad;
    logic        [19:0]         r_us;
    logic signed [47:0]         r_acc_x, r_acc_y;
    logic [HEADING_BITS-1:0]    r_head;
    logic signed [PW-1:0]       r_prod;
    logic signed [CORDIC_W-1:0] r_rx, r_ry;
    logic                       r_neg;
    logic signed [15:0]         r_qw, r_qz;
    logic                       r_out_valid;
    logic signed [31:0]         r_o_px, r_o_py;
    logic        [15:0]         r_o_head;
    logic signed [15:0]         r_o_qz, r_o_qw, r_o_rad;

    logic signed [MAW-1:0]      w_ma;
    logic signed [MBW-1:0]      w_mb;
    logic [31:0]                w_ang;
    logic                       w_cor_start, w_cor_done;
    logic signed [CORDIC_W-1:0] w_cor_x0, w_cor_y0, w_cor_x, w_cor_y;
    logic [31:0]                w_cor_a;
    logic                       w_div_start, w_div_done;
    logic [DIV_W-1:0]           w_dvd, w_quo;
    logic [51:0]                w_abs;
    logic signed [49:0]         w_step, w_sum;
    logic signed [47:0]         w_acc_src, w_acc_sat;
    logic signed [PW-1:0]       w_hsum, w_dh;
    logic signed [39:0]         w_rot, w_qv;
    logic signed [15:0]         w_qr;
    logic                       w_out_free;

    generate
        if (HEADING_BITS >= 32) begin : g_ang_hi
            assign w_ang = r_head[HEADING_BITS-1 -: 32];
        end else begin : g_ang_lo
            assign w_ang = {r_head, {(32 - HEADING_BITS){1'b0}}};
        end
    endgenerate

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_MRAD: begin
                w_ma = MAW'(r_yd);
                w_mb = MBW'($signed({1'b0, DEG2RAD_Q32}));
            end
            S_MHD1: begin
                w_ma = MAW'(r_rad);
                w_mb = MBW'($signed({1'b0, r_us}));
            end
            S_MHD2: begin
                w_ma = r_prod[MAW-1:0];
                w_mb = MBW'($signed({1'b0, INV_2PI_MEGA_Q48}));
            end
            S_MGX, S_MQW: begin
                w_ma = MAW'(w_cor_x);
                w_mb = MBW'($signed({1'b0, INV_GAIN_Q32}));
            end
            S_MGY, S_MQZ: begin
                w_ma = MAW'(w_cor_y);
                w_mb = MBW'($signed({1'b0, INV_GAIN_Q32}));
            end
            S_MPX: begin
                w_ma = MAW'(r_rx);
                w_mb = MBW'($signed({1'b0, r_us}));
            end
            S_MPY: begin
                w_ma = MAW'(r_ry);
                w_mb = MBW'($signed({1'b0, r_us}));
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_cor_start = (r_state == S_MRAD) || (r_state == S_QROT);
    assign w_cor_x0    = (r_state == S_QROT) ? CORDIC_W'(32'sd268435456)
                                             : CORDIC_W'($signed({r_vx, 14'd0}));
    assign w_cor_y0    = (r_state == S_QROT) ? '0 : CORDIC_W'($signed({r_vy, 14'd0}));
    assign w_cor_a     = (r_state == S_QROT) ? {1'b0, w_ang[31:1]} : w_ang;

    odo_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cor_start),
        .i_x     (w_cor_x0),
        .i_y     (w_cor_y0),
        .i_angle (w_cor_a),
        .o_done  (w_cor_done),
        .o_x     (w_cor_x),
        .o_y     (w_cor_y)
    );

    // |r*us|*64 + 500000, rounds ties away from zero after the divide
    assign w_abs       = r_prod[PW-1] ? 52'(-r_prod) : 52'(r_prod);
    assign w_dvd       = {w_abs, 6'd0} + DIV_W'(500000);
    assign w_div_start = (r_state == S_DPX) || (r_state == S_DPY);

    odo_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_acc_src = (r_state == S_WPY) ? r_acc_y : r_acc_x;
    assign w_step    = r_neg ? -$signed({10'd0, w_quo[39:0]})
                             : $signed({10'd0, w_quo[39:0]});
    assign w_sum     = 50'(w_acc_src) + w_step;
    always_comb begin
        if (w_sum[49:47] == 3'b000 || w_sum[49:47] == 3'b111) begin
            w_acc_sat = w_sum[47:0];
        end else if (w_sum[49]) begin
            w_acc_sat = {1'b1, 47'd0};
        end else begin
            w_acc_sat = {1'b0, {47{1'b1}}};
        end
    end

    assign w_hsum = r_prod + (PW'(1) <<< (HSHIFT - 1));
    assign w_dh   = w_hsum >>> HSHIFT;

    assign w_rot = r_prod[PW-1:32];
    assign w_qv  = (w_rot + 40'sd8192) >>> 14;
    always_comb begin
        if (w_qv > 40'sd16384) begin
            w_qr = 16'sd16384;
        end else if (w_qv < -40'sd16384) begin
            w_qr = -16'sd16384;
        end else begin
            w_qr = w_qv[15:0];
        end
    end

    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_prod <= w_ma * w_mb;
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_vx    <= i_in.vel_x;
                        r_vy    <= i_in.vel_y;
                        r_yd    <= i_in.yaw_rate_deg;
                        r_us    <= i_in.elapsed_us;
                        r_state <= S_MRAD;
                    end
                end
                S_MRAD: r_state <= S_RAD;
                S_RAD: begin
                    r_rad   <= 16'((r_prod + PW'(64'sd67108864)) >>> 27);
                    r_state <= S_MHD1;
                end
                S_MHD1: r_state <= S_MHD2;
                S_MHD2: r_state <= S_HEAD;
                S_HEAD: begin
                    r_head  <= r_head + w_dh[HEADING_BITS-1:0];
                    r_state <= S_WROT;
                end
                S_WROT: if (w_cor_done) r_state <= S_MGX;
                S_MGX:  r_state <= S_MGY;
                S_MGY: begin
                    r_rx    <= w_rot[CORDIC_W-1:0];
                    r_state <= S_GY;
                end
                S_GY: begin
                    r_ry    <= w_rot[CORDIC_W-1:0];
                    r_state <= S_MPX;
                end
                S_MPX: r_state <= S_DPX;
                S_DPX: begin
                    r_neg   <= r_prod[PW-1];
                    r_state <= S_WPX;
                end
                S_WPX: begin
                    if (w_div_done) begin
                        r_acc_x <= w_acc_sat;
                        r_state <= S_MPY;
                    end
                end
                S_MPY: r_state <= S_DPY;
                S_DPY: begin
                    r_neg   <= r_prod[PW-1];
                    r_state <= S_WPY;
                end
                S_WPY: begin
                    if (w_div_done) begin
                        r_acc_y <= w_acc_sat;
                        r_state <= S_QROT;
                    end
                end
                S_QROT: r_state <= S_WQ;
                S_WQ:   if (w_cor_done) r_state <= S_MQW;
                S_MQW:  r_state <= S_MQZ;
                S_MQZ: begin
                    r_qw    <= w_qr;
                    r_state <= S_QZ;
                end
                S_QZ: begin
                    r_qz    <= w_qr;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_o_px   <= r_acc_x[47:16];
            r_o_py   <= r_acc_y[47:16];
            r_o_head <= r_head[HEADING_BITS-1 -: 16];
            r_o_qz   <= r_qz;
            r_o_qw   <= r_qw;
            r_o_rad  <= r_rad;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.pos_x        = r_o_px;
    assign o_out.pos_y        = r_o_py;
    assign o_out.heading      = r_o_head;
    assign o_out.quat_z       = r_o_qz;
    assign o_out.quat_w       = r_o_qw;
    assign o_out.yaw_rate_rad = r_o_rad;
endmodule

>>> verif/tb_planar_odometry_integrator.sv
// ----------------------------------------------------------------------------
// tb_planar_odometry_integrator
// Self-checking bench for the odometry integrator. A directed table covers the
// field extremes, zero time steps and large yaw rates. Random motion samples
// follow. Every pose is checked against a fixed-point model of the
// integrator. Sender bursts and receiver stalls are randomized.
// ----------------------------------------------------------------------------
module tb_planar_odometry_integrator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint DEG2RAD  = 64'sd74961321;
    localparam longint INV_GAIN = 64'sd2608131496;
    localparam longint INV_2PI  = 64'sd44798134;
    localparam longint ACC_HI   = 64'sd140737488355327;
    localparam longint ACC_LO   = -64'sd140737488355328;
    localparam int     STEPS    = 16;

    localparam logic [31:0] ATAN [STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [15:0] heading;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] yaw_rate_rad;
    } t_pose;

    typedef struct {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] yd;
        logic        [19:0] us;
        bit                 fixed;   // pose below typed in by hand
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic        [15:0] hd;
        logic signed [15:0] rad;
    } t_motion_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    odo_in_if  in_ch();
    odo_out_if out_ch();

    planar_odometry_integrator dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // model state
    longint      pos_acc_x = 0;
    longint      pos_acc_y = 0;
    logic [31:0] heading_acc = '0;

    t_pose  pending_poses[$];
    int     mismatches = 0;
    int     poses_seen = 0;
    int     requests_sent = 0;
    int     burst_left = 0;
    bit     sender_idle = 1;

    function automatic void rotate_vec(input longint x0, input longint y0,
                                       input logic [31:0] ang,
                                       output longint ox, output longint oy);
        longint x, y, z, dx, dy;
        logic [31:0] a;
        x = x0 * 16384;
        y = y0 * 16384;
        a = ang;
        if (a >= 32'h40000000 && a < 32'hC0000000) begin
            x = -x;
            y = -y;
            a = a - 32'h80000000;
        end
        z = longint'($signed(a));
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - longint'(ATAN[i]);
            end else begin
                x = x + dx; y = y - dy; z = z + longint'(ATAN[i]);
            end
        end
        ox = (x * INV_GAIN) >>> 32;
        oy = (y * INV_GAIN) >>> 32;
    endfunction

    // distance in Q27.20, rounded half away from zero
    function automatic longint travel(input longint r, input longint us);
        longint p, q;
        p = r * us * 64;
        q = ((p < 0 ? -p : p) + 500000) / 1000000;
        return p < 0 ? -q : q;
    endfunction

    function automatic longint clamp_acc(input longint v);
        if (v > ACC_HI) return ACC_HI;
        if (v < ACC_LO) return ACC_LO;
        return v;
    endfunction

    function automatic logic signed [15:0] round_q14(input longint v);
        longint r;
        r = (v + 8192) >>> 14;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    function automatic t_pose integrate_motion(input logic signed [15:0] vx,
                                               input logic signed [15:0] vy,
                                               input logic signed [15:0] yd,
                                               input logic [19:0] us);
        t_pose  p;
        longint rad, rx, ry, dh, qw, qz, t;
        t = longint'(us);
        rad = (longint'(yd) * DEG2RAD + 64'sd67108864) >>> 27;
        rotate_vec(longint'(vx), longint'(vy), heading_acc, rx, ry);
        pos_acc_x = clamp_acc(pos_acc_x + travel(rx, t));
        pos_acc_y = clamp_acc(pos_acc_y + travel(ry, t));
        dh = (rad * t * INV_2PI + 64'sd134217728) >>> 28;
        heading_acc = heading_acc + dh[31:0];
        rotate_vec(64'sd16384, 64'sd0, heading_acc >> 1, qw, qz);
        p.pos_x        = 32'(pos_acc_x >>> 16);
        p.pos_y        = 32'(pos_acc_y >>> 16);
        p.heading      = heading_acc[31:16];
        p.quat_z       = round_q14(qz);
        p.quat_w       = round_q14(qw);
        p.yaw_rate_rad = rad[15:0];
        return p;
    endfunction

    function automatic void note_mismatch(input string what, input longint exp_v,
                                          input longint act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected %0d, got %0d (pose %0d)",
                     what, exp_v, act_v, poses_seen);
    endfunction

    // drive one request, hold it until taken, then maybe pause the sender
    task automatic send_motion(input logic signed [15:0] vx, input logic signed [15:0] vy,
                               input logic signed [15:0] yd, input logic [19:0] us,
                               input int max_gap);
        t_pose p;
        in_ch.valid        <= 1'b1;
        in_ch.vel_x        <= vx;
        in_ch.vel_y        <= vy;
        in_ch.yaw_rate_deg <= yd;
        in_ch.elapsed_us   <= us;
        sender_idle = 0;
        do @(posedge i_clk); while (!in_ch.ready);
        p = integrate_motion(vx, vy, yd, us);
        pending_poses.push_back(p);
        requests_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            if (max_gap > 0 && $urandom_range(0, 3) != 0) begin
                in_ch.valid <= 1'b0;
                sender_idle = 1;
                repeat ($urandom_range(1, max_gap)) @(posedge i_clk);
            end
        end
    endtask

    // receiver: alternates between always-ready, random and long-stall moods
    int stall_mode = 0;
    int mode_left = 0;
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(20, 2000);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 1) == 1);
            default: out_ch.ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_pose e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_poses.size() == 0) begin
                note_mismatch("unexpected pose, x", 0, out_ch.pos_x);
            end else begin
                e = pending_poses.pop_front();
                if (out_ch.pos_x !== e.pos_x) note_mismatch("pos_x", e.pos_x, out_ch.pos_x);
                if (out_ch.pos_y !== e.pos_y) note_mismatch("pos_y", e.pos_y, out_ch.pos_y);
                if (out_ch.heading !== e.heading)
                    note_mismatch("heading", e.heading, out_ch.heading);
                if (out_ch.quat_z !== e.quat_z) note_mismatch("quat_z", e.quat_z, out_ch.quat_z);
                if (out_ch.quat_w !== e.quat_w) note_mismatch("quat_w", e.quat_w, out_ch.quat_w);
                if (out_ch.yaw_rate_rad !== e.yaw_rate_rad)
                    note_mismatch("yaw_rate_rad", e.yaw_rate_rad, out_ch.yaw_rate_rad);
            end
            poses_seen++;
        end
    end

    initial begin
        #60ms;
        $display("Timeout with %0d poses still pending", pending_poses.size());
        $display("Test completed with failures");
        $finish;
    end

    t_motion_row directed_rows[] = '{
        '{16'sd0, 16'sd0, 16'sd0, 20'd0, 1'b1, 32'sd0, 32'sd0, 16'd0, 16'sd0},
        '{16'sd32767, 16'sd0, 16'sd32767, 20'd0, 1'b1, 32'sd0, 32'sd0, 16'd0, 16'sd18301},
        '{16'sd0, -16'sd32768, -16'sd32768, 20'd0, 1'b1, 32'sd0, 32'sd0, 16'd0, -16'sd18301},
        '{16'sd32767, 16'sd0, 16'sd0, 20'hFFFFF, 1'b0, '0, '0, '0, '0},
        '{-16'sd32768, 16'sd0, 16'sd0, 20'hFFFFF, 1'b0, '0, '0, '0, '0},
        '{16'sd0, 16'sd32767, 16'sd0, 20'hFFFFF, 1'b0, '0, '0, '0, '0},
        '{16'sd0, -16'sd32768, 16'sd0, 20'hFFFFF, 1'b0, '0, '0, '0, '0},
        '{16'sd4096, 16'sd0, 16'sd11520, 20'd1000000, 1'b0, '0, '0, '0, '0},
        '{16'sd4096, 16'sd4096, 16'sd11520, 20'd1000000, 1'b0, '0, '0, '0, '0},
        '{16'sd4096, -16'sd4096, 16'sd11520, 20'd1000000, 1'b0, '0, '0, '0, '0},
        '{-16'sd4096, 16'sd4096, 16'sd11520, 20'd1000000, 1'b0, '0, '0, '0, '0},
        '{16'sd4096, 16'sd0, 16'sd32767, 20'hFFFFF, 1'b0, '0, '0, '0, '0},
        '{16'sd4096, 16'sd0, -16'sd32768, 20'hFFFFF, 1'b0, '0, '0, '0, '0},
        '{-16'sd32768, -16'sd32768, -16'sd32768, 20'hFFFFF, 1'b0, '0, '0, '0, '0},
        '{16'sd32767, 16'sd32767, 16'sd32767, 20'hFFFFF, 1'b0, '0, '0, '0, '0},
        '{16'sd32767, 16'sd32767, 16'sd32767, 20'd0, 1'b0, '0, '0, '0, '0},
        '{16'sd1, -16'sd1, 16'sd1, 20'd1, 1'b0, '0, '0, '0, '0},
        '{-16'sd1, 16'sd1, -16'sd1, 20'd45454, 1'b0, '0, '0, '0, '0},
        '{16'sd12288, 16'sd0, -16'sd11520, 20'd500000, 1'b0, '0, '0, '0, '0}
    };

    initial begin
        t_pose p;
        logic signed [15:0] vx, vy, yd;
        logic [19:0] us;

        in_ch.valid        <= 1'b0;
        in_ch.vel_x        <= '0;
        in_ch.vel_y        <= '0;
        in_ch.yaw_rate_deg <= '0;
        in_ch.elapsed_us   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            send_motion(directed_rows[r].vx, directed_rows[r].vy, directed_rows[r].yd,
                        directed_rows[r].us, 20);
            p = pending_poses[$];
            if (directed_rows[r].fixed && (p.pos_x !== directed_rows[r].px ||
                    p.pos_y !== directed_rows[r].py || p.heading !== directed_rows[r].hd ||
                    p.yaw_rate_rad !== directed_rows[r].rad))
                note_mismatch("hand-typed pose row", r, p.yaw_rate_rad);
        end

        // random motion: mostly ~22 Hz steps, some zero and full-range ones
        repeat (1130) begin
            vx = 16'($urandom);
            vy = 16'($urandom);
            yd = 16'($urandom);
            case ($urandom_range(0, 9))
                0:       us = 20'd0;
                1, 2:    us = 20'($urandom);
                default: us = 20'($urandom_range(30000, 60000));
            endcase
            if ($urandom_range(0, 3) == 0) begin
                vx = $signed(vx) >>> 4;
                vy = $signed(vy) >>> 4;
                yd = $signed(yd) >>> 6;
            end
            send_motion(vx, vy, yd, us, 40);
        end

        if (!sender_idle) in_ch.valid <= 1'b0;
        while (pending_poses.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);

        $display("Sent %0d motion samples (%0d directed rows, rest random), checked %0d poses",
                 requests_sent, directed_rows.size(), poses_seen);
        $display("Bursty sender and stalling receiver throughout, %0d mismatches", mismatches);
        if (mismatches == 0 && pending_poses.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
